/* sv/crbu_pkg.sv */
`default_nettype none
package crbu_pkg;

	localparam int EXC_LEVELS_DEF = 4;

	// Operation codes carried in the mode field.
	localparam logic [4:0] MODE_ADDSP     = 5'd0;
	localparam logic [4:0] MODE_WR_ECSR   = 5'd1;
	localparam logic [4:0] MODE_WR_ELR    = 5'd2;
	localparam logic [4:0] MODE_WR_EPSW   = 5'd3;
	localparam logic [4:0] MODE_RD_ELR    = 5'd4;
	localparam logic [4:0] MODE_RD_SP     = 5'd5;
	localparam logic [4:0] MODE_WR_PSW    = 5'd6;
	localparam logic [4:0] MODE_RD_ECSR   = 5'd7;
	localparam logic [4:0] MODE_RD_EPSW   = 5'd8;
	localparam logic [4:0] MODE_RD_PSW    = 5'd9;
	localparam logic [4:0] MODE_WR_SP     = 5'd10;
	localparam logic [4:0] MODE_LEA       = 5'd11;
	localparam logic [4:0] MODE_PSW_OR    = 5'd12;
	localparam logic [4:0] MODE_PSW_AND   = 5'd13;
	localparam logic [4:0] MODE_CPLC      = 5'd14;
	localparam logic [4:0] MODE_BC        = 5'd15;
	localparam logic [4:0] MODE_B         = 5'd16;
	localparam logic [4:0] MODE_BL        = 5'd17;
	localparam logic [4:0] MODE_RT        = 5'd18;
	localparam logic [4:0] MODE_RTI       = 5'd19;

	// Branch condition codes.
	localparam logic [3:0] COND_NC  = 4'd0;
	localparam logic [3:0] COND_C   = 4'd1;
	localparam logic [3:0] COND_GT  = 4'd2;
	localparam logic [3:0] COND_LE  = 4'd3;
	localparam logic [3:0] COND_GES = 4'd4;
	localparam logic [3:0] COND_LTS = 4'd5;
	localparam logic [3:0] COND_GTS = 4'd6;
	localparam logic [3:0] COND_LES = 4'd7;
	localparam logic [3:0] COND_NZ  = 4'd8;
	localparam logic [3:0] COND_Z   = 4'd9;
	localparam logic [3:0] COND_NV  = 4'd10;
	localparam logic [3:0] COND_V   = 4'd11;
	localparam logic [3:0] COND_PS  = 4'd12;
	localparam logic [3:0] COND_NS  = 4'd13;
	localparam logic [3:0] COND_AL  = 4'd14;
	localparam logic [3:0] COND_AL2 = 4'd15;

	localparam int FLAG_C_BIT  = 7;
	localparam int FLAG_Z_BIT  = 6;
	localparam int FLAG_S_BIT  = 5;
	localparam int FLAG_OV_BIT = 4;

	localparam logic [15:0] SP_EVEN_MASK = 16'hfffe;
	localparam logic [15:0] SEXT8_HI     = 16'hff00;
	localparam logic [15:0] BC_SEXT_HI   = 16'h7f00;
	localparam logic [7:0]  FLAG_C       = 8'h80;

	typedef struct packed {
		logic [4:0]  mode;
		logic [15:0] operand;
		logic [15:0] long_imm;
		logic        long_form;
		logic        has_register;
		logic [3:0]  cond;
		logic [7:0]  flags_in;
		logic [15:0] pc_next;
	} instr_t;

	typedef struct packed {
		logic [15:0] read_value;
		logic [15:0] new_pc;
		logic [3:0]  new_csr;
		logic        taken;
		logic [7:0]  psw_out;
		logic [15:0] sp_out;
		logic [15:0] ea_out;
	} result_t;

endpackage
`default_nettype wire

/* sv/crbu_cond.sv */
`default_nettype none
module crbu_cond (
	input  wire logic [3:0] cond,
	input  wire logic [7:0] flags,
	output logic            holds
);

	logic c;
	logic z;
	logic s;
	logic ov;
	logic le;
	logic lts;
	logic les;

	assign c   = flags[crbu_pkg::FLAG_C_BIT];
	assign z   = flags[crbu_pkg::FLAG_Z_BIT];
	assign s   = flags[crbu_pkg::FLAG_S_BIT];
	assign ov  = flags[crbu_pkg::FLAG_OV_BIT];
	assign le  = z | c;
	assign lts = ov ^ s;
	assign les = lts | z;

	always_comb begin
		unique case (cond)
			crbu_pkg::COND_NC:  holds = !c;
			crbu_pkg::COND_C:   holds = c;
			crbu_pkg::COND_GT:  holds = !le;
			crbu_pkg::COND_LE:  holds = le;
			crbu_pkg::COND_GES: holds = !lts;
			crbu_pkg::COND_LTS: holds = lts;
			crbu_pkg::COND_GTS: holds = !les;
			crbu_pkg::COND_LES: holds = les;
			crbu_pkg::COND_NZ:  holds = !z;
			crbu_pkg::COND_Z:   holds = z;
			crbu_pkg::COND_NV:  holds = !ov;
			crbu_pkg::COND_V:   holds = ov;
			crbu_pkg::COND_PS:  holds = !s;
			crbu_pkg::COND_NS:  holds = s;
			// The two remaining codes always branch.
			default:            holds = 1'b1;
		endcase
	end

endmodule
`default_nettype wire

/* sv/crbu_exec.sv */
`default_nettype none
module crbu_exec #(
	parameter int EXC_LEVELS = crbu_pkg::EXC_LEVELS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire crbu_pkg::instr_t instr,
	output crbu_pkg::result_t     res
);

	localparam int LW = (EXC_LEVELS > 1) ? $clog2(EXC_LEVELS) : 1;

	logic [15:0] sp_q;
	logic [7:0]  psw_q;
	logic [15:0] ea_q;
	logic [3:0]  csr_q;
	logic [15:0] lr_q;
	logic [3:0]  lcsr_q;
	logic [3:0]  ecsr_q [EXC_LEVELS];
	logic [15:0] elr_q  [EXC_LEVELS];
	logic [7:0]  epsw_q [EXC_LEVELS];

	logic [15:0] sp_n;
	logic [7:0]  psw_n;
	logic [15:0] ea_n;
	logic [3:0]  csr_n;
	logic [15:0] lr_n;
	logic [3:0]  lcsr_n;
	logic        wr_ecsr;
	logic        wr_elr;
	logic        wr_epsw;

	logic [1:0]    lv;
	logic          lv_ok;
	logic [LW-1:0] idx;
	logic [3:0]    ecsr_rd;
	logic [15:0]   elr_rd;
	logic [7:0]    epsw_rd;
	logic [7:0]    lo;
	logic [15:0]   sp_sum;
	logic [15:0]   bc_target;
	logic [15:0]   lea_sum;
	logic          cond_ok;

	assign lv      = psw_q[1:0];
	assign lv_ok   = 32'(lv) < EXC_LEVELS;
	assign idx     = LW'(lv);
	assign ecsr_rd = lv_ok ? ecsr_q[idx] : 4'd0;
	assign elr_rd  = lv_ok ? elr_q[idx]  : 16'd0;
	assign epsw_rd = lv_ok ? epsw_q[idx] : 8'd0;
	assign lo      = instr.operand[7:0];

	assign sp_sum    = sp_q + ({8'd0, lo} | (lo[7] ? crbu_pkg::SEXT8_HI : 16'd0));
	// The offset counts instruction words, so it is doubled before the add.
	assign bc_target = instr.pc_next
		+ 16'(({8'd0, lo} | (lo[7] ? crbu_pkg::BC_SEXT_HI : 16'd0)) << 1);
	assign lea_sum   = (instr.has_register ? instr.operand : 16'd0)
		+ (instr.long_form ? instr.long_imm : 16'd0);

	crbu_cond u_cond (
		.cond  (instr.cond),
		.flags (instr.flags_in),
		.holds (cond_ok)
	);

	always_comb begin
		sp_n    = sp_q;
		psw_n   = psw_q;
		ea_n    = ea_q;
		csr_n   = csr_q;
		lr_n    = lr_q;
		lcsr_n  = lcsr_q;
		wr_ecsr = 1'b0;
		wr_elr  = 1'b0;
		wr_epsw = 1'b0;
		res.read_value = instr.operand;
		res.new_pc     = instr.pc_next;
		res.taken      = 1'b0;
		unique case (instr.mode)
			crbu_pkg::MODE_ADDSP:   sp_n = sp_sum & crbu_pkg::SP_EVEN_MASK;
			crbu_pkg::MODE_WR_ECSR: wr_ecsr = lv_ok;
			crbu_pkg::MODE_WR_ELR:  wr_elr = lv_ok;
			crbu_pkg::MODE_WR_EPSW: wr_epsw = lv_ok && (lv != 2'd0);
			crbu_pkg::MODE_RD_ELR:  res.read_value = elr_rd;
			crbu_pkg::MODE_RD_SP:   res.read_value = sp_q;
			crbu_pkg::MODE_WR_PSW:  psw_n = lo;
			crbu_pkg::MODE_RD_ECSR: res.read_value = {12'd0, ecsr_rd};
			crbu_pkg::MODE_RD_EPSW: begin
				if (lv != 2'd0) begin
					res.read_value = {8'd0, epsw_rd};
				end
			end
			crbu_pkg::MODE_RD_PSW:  res.read_value = {8'd0, psw_q};
			crbu_pkg::MODE_WR_SP:   sp_n = instr.operand & crbu_pkg::SP_EVEN_MASK;
			crbu_pkg::MODE_LEA:     ea_n = lea_sum;
			crbu_pkg::MODE_PSW_OR:  psw_n = psw_q | lo;
			crbu_pkg::MODE_PSW_AND: psw_n = psw_q & lo;
			crbu_pkg::MODE_CPLC:    psw_n = psw_q ^ crbu_pkg::FLAG_C;
			crbu_pkg::MODE_BC: begin
				if (cond_ok) begin
					res.new_pc = bc_target;
					res.taken  = 1'b1;
				end
			end
			crbu_pkg::MODE_B, crbu_pkg::MODE_BL: begin
				if (instr.mode == crbu_pkg::MODE_BL) begin
					lr_n   = instr.pc_next;
					lcsr_n = csr_q;
				end
				if (instr.long_form) begin
					csr_n      = instr.operand[3:0];
					res.new_pc = instr.long_imm;
				end else begin
					res.new_pc = instr.operand;
				end
				res.taken = 1'b1;
			end
			crbu_pkg::MODE_RT: begin
				csr_n      = lcsr_q;
				res.new_pc = lr_q;
				res.taken  = 1'b1;
			end
			crbu_pkg::MODE_RTI: begin
				csr_n      = ecsr_rd;
				res.new_pc = elr_rd;
				psw_n      = epsw_rd;
				res.taken  = 1'b1;
			end
			default: begin
			end
		endcase
		res.new_csr = csr_n;
		res.psw_out = psw_n;
		res.sp_out  = sp_n;
		res.ea_out  = ea_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q   <= '0;
			psw_q  <= '0;
			ea_q   <= '0;
			csr_q  <= '0;
			lr_q   <= '0;
			lcsr_q <= '0;
			for (int i = 0; i < EXC_LEVELS; i++) begin
				ecsr_q[i] <= '0;
				elr_q[i]  <= '0;
				epsw_q[i] <= '0;
			end
		end else if (fire) begin
			sp_q   <= sp_n;
			psw_q  <= psw_n;
			ea_q   <= ea_n;
			csr_q  <= csr_n;
			lr_q   <= lr_n;
			lcsr_q <= lcsr_n;
			if (wr_ecsr) begin
				ecsr_q[idx] <= instr.operand[3:0];
			end
			if (wr_elr) begin
				elr_q[idx] <= instr.operand;
			end
			if (wr_epsw) begin
				epsw_q[idx] <= lo;
			end
		end
	end

	a_sp_even: assert property (@(posedge clk) disable iff (!arst_n) !sp_q[0])
		else $error("stack pointer became odd");

	a_epsw0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		epsw_q[0] == 8'd0)
		else $error("level-zero EPSW entry was written");

	a_taken_mode: assert property (@(posedge clk) disable iff (!arst_n)
		res.taken |-> (instr.mode == crbu_pkg::MODE_BC || instr.mode == crbu_pkg::MODE_B
			|| instr.mode == crbu_pkg::MODE_BL || instr.mode == crbu_pkg::MODE_RT
			|| instr.mode == crbu_pkg::MODE_RTI))
		else $error("redirect from a non-branch operation");

	a_seq_pc: assert property (@(posedge clk) disable iff (!arst_n)
		!res.taken |-> res.new_pc == instr.pc_next)
		else $error("PC changed without a redirect");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(sp_q) && $stable(psw_q) && $stable(csr_q))
		else $error("state changed without a transfer");

endmodule
`default_nettype wire

/* sv/control_register_branch_unit.sv */
// Pipeline: a transfer accepted into the input register then executes into the result register,
// where it waits while res_stall holds it.
// Throughput: one instruction per cycle while the result register is not held by res_stall.
// Reset clears both valid flags and every architectural register, banks included.
`default_nettype none
module control_register_branch_unit #(
	parameter int EXC_LEVELS = crbu_pkg::EXC_LEVELS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              instr_valid,
	output logic                   instr_stall,
	input  wire crbu_pkg::instr_t  instr,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output crbu_pkg::result_t      res
);

	logic              valid_s1;
	crbu_pkg::instr_t  instr_s1;
	logic              res_valid_q;
	crbu_pkg::result_t res_q;
	crbu_pkg::result_t res_d;
	logic              adv;
	logic              fire;

	// The execute stage moves whenever the result register is empty or drained.
	assign adv         = !res_valid_q || !res_stall;
	assign fire        = valid_s1 && adv;
	assign instr_stall = valid_s1 && !adv;
	assign res_valid   = res_valid_q;
	assign res         = res_q;

	crbu_exec #(
		.EXC_LEVELS (EXC_LEVELS)
	) u_exec (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.instr  (instr_s1),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (instr_valid && !instr_stall) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (instr_valid && !instr_stall) begin
			instr_s1 <= instr;
		end
		if (fire) begin
			res_q <= res_d;
		end
	end

endmodule
`default_nettype wire

/* sim/tb_control_register_branch_unit.sv */
module tb_control_register_branch_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int EXC_LVLS    = crbu_pkg::EXC_LEVELS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 100;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              instr_valid = 1'b0;
	logic              instr_stall;
	crbu_pkg::instr_t  instr       = '0;
	logic              res_valid;
	logic              res_stall   = 1'b0;
	crbu_pkg::result_t res;

	// Architectural state as this testbench tracks it.
	logic [15:0] stack_ptr   = '0;
	logic [7:0]  status_word = '0;
	logic [15:0] eff_addr    = '0;
	logic [3:0]  code_seg    = '0;
	logic [15:0] link_pc     = '0;
	logic [3:0]  link_seg    = '0;
	logic [3:0]  exc_seg_bank    [EXC_LVLS];
	logic [15:0] exc_link_bank   [EXC_LVLS];
	logic [7:0]  exc_status_bank [EXC_LVLS];

	crbu_pkg::instr_t  pending_instrs[$];
	crbu_pkg::result_t expected_results[$];
	int      error_count    = 0;
	int      cycle_count    = 0;
	int      send_idle_pct  = 0;
	int      recv_stall_pct = 0;

	control_register_branch_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr_valid (instr_valid),
		.instr_stall (instr_stall),
		.instr       (instr),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic branch_cond_met(logic [3:0] cc, logic [7:0] fl);
		logic c, z, s, ov, lts;
		c   = fl[crbu_pkg::FLAG_C_BIT];
		z   = fl[crbu_pkg::FLAG_Z_BIT];
		s   = fl[crbu_pkg::FLAG_S_BIT];
		ov  = fl[crbu_pkg::FLAG_OV_BIT];
		lts = ov ^ s;
		case (cc)
		crbu_pkg::COND_NC:  return !c;
		crbu_pkg::COND_C:   return c;
		crbu_pkg::COND_GT:  return !(z | c);
		crbu_pkg::COND_LE:  return z | c;
		crbu_pkg::COND_GES: return !lts;
		crbu_pkg::COND_LTS: return lts;
		crbu_pkg::COND_GTS: return !(lts | z);
		crbu_pkg::COND_LES: return lts | z;
		crbu_pkg::COND_NZ:  return !z;
		crbu_pkg::COND_Z:   return z;
		crbu_pkg::COND_NV:  return !ov;
		crbu_pkg::COND_V:   return ov;
		crbu_pkg::COND_PS:  return !s;
		crbu_pkg::COND_NS:  return s;
		default:            return 1'b1;
		endcase
	endfunction

	// Executes one instruction against the tracked state and returns its result.
	function automatic crbu_pkg::result_t execute_instr(crbu_pkg::instr_t ins);
		crbu_pkg::result_t r;
		logic [1:0]  lvl;
		logic        bank_ok;
		logic [7:0]  lo;
		logic [15:0] ea;
		lvl     = status_word[1:0];
		bank_ok = int'(lvl) < EXC_LVLS;
		lo      = ins.operand[7:0];
		r            = '0;
		r.read_value = ins.operand;
		r.new_pc     = ins.pc_next;
		r.taken      = 1'b0;
		case (ins.mode)
		crbu_pkg::MODE_ADDSP: stack_ptr = (stack_ptr
				+ {(lo[7] ? crbu_pkg::SEXT8_HI[15:8] : 8'h00), lo})
				& crbu_pkg::SP_EVEN_MASK;
		crbu_pkg::MODE_WR_ECSR: if (bank_ok) exc_seg_bank[lvl] = ins.operand[3:0];
		crbu_pkg::MODE_WR_ELR:  if (bank_ok) exc_link_bank[lvl] = ins.operand;
		crbu_pkg::MODE_WR_EPSW: if (lvl != 2'd0 && bank_ok) exc_status_bank[lvl] = lo;
		crbu_pkg::MODE_RD_ELR:  r.read_value = bank_ok ? exc_link_bank[lvl] : 16'h0000;
		crbu_pkg::MODE_RD_SP:   r.read_value = stack_ptr;
		crbu_pkg::MODE_WR_PSW:  status_word = lo;
		crbu_pkg::MODE_RD_ECSR:
			r.read_value = bank_ok ? {12'h000, exc_seg_bank[lvl]} : 16'h0000;
		crbu_pkg::MODE_RD_EPSW: if (lvl != 2'd0) begin
			r.read_value = bank_ok ? {8'h00, exc_status_bank[lvl]} : 16'h0000;
		end
		crbu_pkg::MODE_RD_PSW:  r.read_value = {8'h00, status_word};
		crbu_pkg::MODE_WR_SP:   stack_ptr = ins.operand & crbu_pkg::SP_EVEN_MASK;
		crbu_pkg::MODE_LEA: begin
			ea = '0;
			if (ins.has_register) ea = ea + ins.operand;
			if (ins.long_form) ea = ea + ins.long_imm;
			eff_addr = ea;
		end
		crbu_pkg::MODE_PSW_OR:  status_word = status_word | lo;
		crbu_pkg::MODE_PSW_AND: status_word = status_word & lo;
		crbu_pkg::MODE_CPLC:    status_word = status_word ^ crbu_pkg::FLAG_C;
		crbu_pkg::MODE_BC: if (branch_cond_met(ins.cond, ins.flags_in)) begin
			// Offset is the signed byte in halfwords.
			r.new_pc = ins.pc_next + {{7{lo[7]}}, lo, 1'b0};
			r.taken  = 1'b1;
		end
		crbu_pkg::MODE_B, crbu_pkg::MODE_BL: begin
			if (ins.mode == crbu_pkg::MODE_BL) begin
				link_pc  = ins.pc_next;
				link_seg = code_seg;
			end
			if (ins.long_form) begin
				code_seg = ins.operand[3:0];
				r.new_pc = ins.long_imm;
			end else begin
				r.new_pc = ins.operand;
			end
			r.taken = 1'b1;
		end
		crbu_pkg::MODE_RT: begin
			code_seg = link_seg;
			r.new_pc = link_pc;
			r.taken  = 1'b1;
		end
		crbu_pkg::MODE_RTI: begin
			if (bank_ok) begin
				code_seg    = exc_seg_bank[lvl];
				r.new_pc    = exc_link_bank[lvl];
				status_word = exc_status_bank[lvl];
			end else begin
				code_seg    = '0;
				r.new_pc    = '0;
				status_word = '0;
			end
			r.taken = 1'b1;
		end
		default: ;
		endcase
		r.new_csr = code_seg;
		r.psw_out = status_word;
		r.sp_out  = stack_ptr;
		r.ea_out  = eff_addr;
		return r;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endfunction

	function automatic crbu_pkg::instr_t instr_of(logic [4:0] mode, logic [15:0] operand,
			logic [15:0] long_imm, logic long_form, logic has_register,
			logic [3:0] cond, logic [15:0] pc_next);
		crbu_pkg::instr_t ins;
		ins.mode         = mode;
		ins.operand      = operand;
		ins.long_imm     = long_imm;
		ins.long_form    = long_form;
		ins.has_register = has_register;
		ins.cond         = cond;
		ins.flags_in     = 8'($urandom);
		ins.pc_next      = pc_next;
		return ins;
	endfunction

	function automatic crbu_pkg::instr_t random_instr();
		crbu_pkg::instr_t ins;
		ins = instr_of(5'($urandom_range(0, 19)), 16'($urandom), 16'($urandom),
			1'($urandom), 1'($urandom), 4'($urandom), 16'($urandom));
		// A few opcodes outside the defined set.
		if ($urandom_range(0, 99) < 5) ins.mode = 5'($urandom_range(20, 31));
		return ins;
	endfunction

	function automatic void queue_instr(crbu_pkg::instr_t ins);
		pending_instrs = {pending_instrs, ins};
	endfunction

	task automatic wait_for_drain();
		while (pending_instrs.size() != 0 || instr_valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	// Driver: the expected result is computed at the edge where the transfer happens.
	always @(posedge clk) begin
		if (!arst_n) begin
			instr_valid <= 1'b0;
		end else begin
			if (instr_valid && !instr_stall) begin
				expected_results = {expected_results, execute_instr(instr)};
			end
			if (!instr_valid || !instr_stall) begin
				if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					instr_valid <= 1'b1;
					instr       <= pending_instrs.pop_front();
				end else begin
					instr_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= $urandom_range(0, 99) < recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		crbu_pkg::result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no instruction outstanding");
				error_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("read_value", want.read_value, res.read_value);
				check_field("new_pc", want.new_pc, res.new_pc);
				check_field("new_csr", 16'(want.new_csr), 16'(res.new_csr));
				check_field("taken", 16'(want.taken), 16'(res.taken));
				check_field("psw_out", 16'(want.psw_out), 16'(res.psw_out));
				check_field("sp_out", want.sp_out, res.sp_out);
				check_field("ea_out", want.ea_out, res.ea_out);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int          send_idle [4];
		int          recv_stall[4];
		int          count;
		logic [15:0] psw_val;
		send_idle  = '{0, 84, 0, 25};
		recv_stall = '{0, 0, 84, 25};
		for (int i = 0; i < EXC_LVLS; i++) begin
			exc_seg_bank[i]    = '0;
			exc_link_bank[i]   = '0;
			exc_status_bank[i] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Stack pointer arithmetic, sign extension and the even mask.
		queue_instr(instr_of(crbu_pkg::MODE_ADDSP, 16'h0080, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h0100));
		queue_instr(instr_of(crbu_pkg::MODE_ADDSP, 16'hff7f, 16'hffff,
			1'b1, 1'b1, 4'd0, 16'h0102));
		queue_instr(instr_of(crbu_pkg::MODE_WR_SP, 16'hffff, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h0104));
		queue_instr(instr_of(crbu_pkg::MODE_RD_SP, 16'h0000, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h0106));
		// At level zero the EPSW write is dropped and its read passes the operand.
		queue_instr(instr_of(crbu_pkg::MODE_WR_PSW, 16'h0000, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h0108));
		queue_instr(instr_of(crbu_pkg::MODE_WR_EPSW, 16'h005a, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h010a));
		queue_instr(instr_of(crbu_pkg::MODE_RD_EPSW, 16'ha5a5, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h010c));
		queue_instr(instr_of(crbu_pkg::MODE_WR_ELR, 16'hbeef, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h010e));
		queue_instr(instr_of(crbu_pkg::MODE_RTI, 16'h0000, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h0110));
		// Banked registers at the top level.
		queue_instr(instr_of(crbu_pkg::MODE_WR_PSW, 16'hffff, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h0200));
		queue_instr(instr_of(crbu_pkg::MODE_WR_ECSR, 16'hffff, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h0202));
		queue_instr(instr_of(crbu_pkg::MODE_WR_EPSW, 16'h0081, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h0204));
		queue_instr(instr_of(crbu_pkg::MODE_WR_ELR, 16'h0001, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h0206));
		queue_instr(instr_of(crbu_pkg::MODE_RD_ECSR, 16'h1111, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h0208));
		queue_instr(instr_of(crbu_pkg::MODE_RD_ELR, 16'h2222, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h020a));
		queue_instr(instr_of(crbu_pkg::MODE_RD_EPSW, 16'h3333, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h020c));
		queue_instr(instr_of(crbu_pkg::MODE_RD_PSW, 16'h4444, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h020e));
		queue_instr(instr_of(crbu_pkg::MODE_CPLC, 16'h0000, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h0210));
		queue_instr(instr_of(crbu_pkg::MODE_PSW_AND, 16'hff0f, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h0212));
		queue_instr(instr_of(crbu_pkg::MODE_PSW_OR, 16'h00f0, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h0214));
		queue_instr(instr_of(crbu_pkg::MODE_RTI, 16'h0000, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h0216));
		// Address computation, branches with wraparound, call and return, and an undefined opcode.
		queue_instr(instr_of(crbu_pkg::MODE_LEA, 16'hffff, 16'hffff,
			1'b1, 1'b1, 4'd0, 16'h0300));
		queue_instr(instr_of(crbu_pkg::MODE_LEA, 16'hffff, 16'hffff,
			1'b0, 1'b0, 4'd0, 16'h0302));
		queue_instr(instr_of(crbu_pkg::MODE_BC, 16'h0080, 16'h0000,
			1'b0, 1'b0, crbu_pkg::COND_AL2, 16'h0010));
		queue_instr(instr_of(crbu_pkg::MODE_BC, 16'h007f, 16'h0000,
			1'b0, 1'b0, crbu_pkg::COND_AL, 16'hffff));
		queue_instr(instr_of(crbu_pkg::MODE_BL, 16'h000f, 16'hffff,
			1'b1, 1'b0, 4'd0, 16'h0400));
		queue_instr(instr_of(crbu_pkg::MODE_B, 16'h1234, 16'h5678,
			1'b0, 1'b0, 4'd0, 16'h0402));
		queue_instr(instr_of(crbu_pkg::MODE_RT, 16'h0000, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h0404));
		queue_instr(instr_of(5'd31, 16'hcafe, 16'h0000,
			1'b0, 1'b0, 4'd0, 16'h0406));
		wait_for_drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = send_idle[ph];
			recv_stall_pct = recv_stall[ph];
			count = 0;
			while (count < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) < 3) begin
					// Exception frame: pick a level, fill its bank, call, return, leave.
					psw_val = 16'($urandom);
					queue_instr(instr_of(crbu_pkg::MODE_WR_PSW, psw_val, 16'($urandom),
						1'b0, 1'b0, 4'd0, 16'($urandom)));
					queue_instr(instr_of(crbu_pkg::MODE_WR_ECSR, 16'($urandom),
						16'($urandom), 1'b0, 1'b0, 4'd0, 16'($urandom)));
					queue_instr(instr_of(crbu_pkg::MODE_WR_ELR, 16'($urandom),
						16'($urandom), 1'b0, 1'b0, 4'd0, 16'($urandom)));
					queue_instr(instr_of(crbu_pkg::MODE_WR_EPSW, 16'($urandom),
						16'($urandom), 1'b0, 1'b0, 4'd0, 16'($urandom)));
					queue_instr(instr_of(crbu_pkg::MODE_BL, 16'($urandom), 16'($urandom),
						1'($urandom), 1'b0, 4'd0, 16'($urandom)));
					queue_instr(instr_of(crbu_pkg::MODE_RT, 16'($urandom), 16'($urandom),
						1'b0, 1'b0, 4'd0, 16'($urandom)));
					queue_instr(instr_of(crbu_pkg::MODE_RTI, 16'($urandom), 16'($urandom),
						1'b0, 1'b0, 4'd0, 16'($urandom)));
					count += 7;
				end else begin
					queue_instr(random_instr());
					count++;
				end
			end
			wait_for_drain();
		end

		repeat (10) @(negedge clk);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
